>>> rtl/fqks_pkg.sv
`timescale 1ns / 1ps
// shared types and constants for the keyed fifo queue
// no dependencies; imported by the engine and the top level

package fqks_pkg;

   localparam int KEY_W       = 47;
   localparam int CAT_W       = 8;
   localparam int NAME_W      = 32;
   localparam int SKIP_W      = 5;
   localparam int POS_W       = 5;
   localparam int MAX_RESULTS = 16;
   localparam int NW          = $clog2(MAX_RESULTS + 1);

   typedef enum logic [2:0] {
      OP_APPEND   = 3'd0,
      OP_DROP     = 3'd1,
      OP_FIND_KEY = 3'd2,
      OP_FIND_CAT = 3'd3,
      OP_REMOVE   = 3'd4,
      OP_LIST     = 3'd5
   } op_type;

   typedef enum logic [2:0] {
      ST_OK        = 3'd0,
      ST_EMPTY     = 3'd1,
      ST_FULL      = 3'd2,
      ST_NOT_FOUND = 3'd3,
      ST_TOO_FEW   = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      S_IDLE,
      S_WALK,
      S_FINISH
   } state_type;

   // one stored record
   typedef struct packed {
      logic [KEY_W-1:0]  key;
      logic [CAT_W-1:0]  category;
      logic [NAME_W-1:0] name;
   } rec_type;

   localparam int REC_W = $bits(rec_type);

   // one request as unpacked from the input stream
   typedef struct packed {
      logic [2:0]        opcode;
      logic [KEY_W-1:0]  record_key;
      logic [CAT_W-1:0]  record_category;
      logic [NAME_W-1:0] record_name;
      logic [SKIP_W-1:0] skip_amount;
   } cmd_type;

   // one result handed from the engine to the output register
   typedef struct packed {
      status_type        status;
      logic [POS_W-1:0]  position;
      logic [KEY_W-1:0]  found_key;
      logic [CAT_W-1:0]  found_category;
      logic [NAME_W-1:0] found_name;
      logic              last;
   } rsp_type;

endpackage

>>> rtl/fqks_ram.sv
`timescale 1ns / 1ps
// generic simple dual-port ram, one write and one registered read port
// no dependencies

module fqks_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // write port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
   end

   // read port, data holds until the next read
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> rtl/fqks_engine.sv
`timescale 1ns / 1ps
// queue engine: head/count pointers, record ram and the walk sequencer
// depends on fqks_pkg and fqks_ram

module fqks_engine #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             cmd_valid,
   output logic             cmd_ready,
   input  fqks_pkg::cmd_type cmd,
   output logic             res_valid,
   input  logic             res_ready,
   output fqks_pkg::rsp_type res
);

   import fqks_pkg::*;

   localparam int IDX = $clog2(QUEUE_DEPTH);
   localparam int OFF = $clog2(QUEUE_DEPTH + 1);
   localparam int CW  = (OFF > POS_W) ? OFF : POS_W;

   // physical slot of a queue offset, offset at most the depth
   function automatic logic [IDX-1:0] phys(input logic [IDX-1:0] head,
                                          input logic [OFF-1:0] off);
      logic [IDX:0] sum;
      sum = (IDX+1)'(head) + (IDX+1)'(off);
      if (sum >= (IDX+1)'(QUEUE_DEPTH)) begin
         sum = sum - (IDX+1)'(QUEUE_DEPTH);
      end
      return sum[IDX-1:0];
   endfunction

   state_type         state_ff, state_in;
   logic [2:0]        op_ff, op_in;
   logic [KEY_W-1:0]  key_ff, key_in;
   logic [CAT_W-1:0]  cat_ff, cat_in;
   logic [IDX-1:0]    head_ff, head_in;
   logic [OFF-1:0]    count_ff, count_in;
   logic [OFF-1:0]    rd_off_ff, rd_off_in;
   logic [OFF-1:0]    d_off_ff, d_off_in;
   logic [OFF-1:0]    start_ff, start_in;
   logic              dv_ff, dv_in;
   logic              stop_ff, stop_in;
   logic [NW-1:0]     n_ff, n_in;
   rec_type           held_ff, held_in;
   logic [POS_W-1:0]  held_pos_ff, held_pos_in;
   logic              held_valid_ff, held_valid_in;
   status_type        status_ff, status_in;

   logic              wr_en;
   logic [IDX-1:0]    wr_addr;
   logic [REC_W-1:0]  wr_data;
   logic              rd_en;
   logic [IDX-1:0]    rd_addr;
   logic [REC_W-1:0]  rd_data;
   rec_type           rd_rec;

   logic              is_search;
   logic              hit;
   logic              take;
   logic              stall;
   logic              consume;
   logic              walk_done;
   logic [NW-1:0]     cap;
   logic [CW:0]       d_pos_w;
   logic [CW:0]       app_pos_w;
   logic [CW-1:0]     rm_off_w;
   logic              accept;
   rec_type           cmd_rec;

   fqks_ram #(
      .WIDTH (REC_W),
      .DEPTH (QUEUE_DEPTH)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   assign rd_rec = rd_data;
   assign cmd_rec.key      = cmd.record_key;
   assign cmd_rec.category = cmd.record_category;
   assign cmd_rec.name     = cmd.record_name;

   // walk datapath: match test on the ram output and stall on a full output
   assign is_search = (op_ff != OP_REMOVE);
   assign hit = (op_ff == OP_DROP) || (op_ff == OP_LIST)
              || ((op_ff == OP_FIND_KEY) && (rd_rec.key == key_ff))
              || ((op_ff == OP_FIND_CAT) && (rd_rec.category == cat_ff));
   assign take    = (state_ff == S_WALK) && dv_ff && !stop_ff && is_search && hit;
   assign stall   = take && held_valid_ff && !res_ready;
   assign consume = dv_ff && !stall;
   assign rd_en   = (state_ff == S_WALK) && !stop_ff && !stall && (rd_off_ff < count_ff);
   assign rd_addr = phys(head_ff, rd_off_ff);
   assign walk_done = (state_ff == S_WALK) && !dv_ff
                    && (stop_ff || (rd_off_ff >= count_ff));
   assign cap = ((op_ff == OP_DROP) || (op_ff == OP_FIND_KEY)) ? NW'(1) : NW'(MAX_RESULTS);
   assign d_pos_w   = (CW+1)'(d_off_ff) + (CW+1)'(1);
   assign app_pos_w = (CW+1)'(count_ff) + (CW+1)'(1);
   assign rm_off_w  = (cmd.skip_amount == '0) ? CW'(1) : CW'(cmd.skip_amount);
   assign cmd_ready = (state_ff == S_IDLE);
   assign accept    = cmd_valid && cmd_ready;

   // ram write: append in idle, shift-up during a removal walk
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = phys(head_ff, count_ff);
      wr_data = cmd_rec;
      if (accept && (cmd.opcode == OP_APPEND)
          && (count_ff != OFF'(QUEUE_DEPTH))) begin
         wr_en = 1'b1;
      end else if ((state_ff == S_WALK) && !is_search && consume
                   && (d_off_ff != start_ff)) begin
         wr_en   = 1'b1;
         wr_addr = phys(head_ff, d_off_ff - OFF'(1));
         wr_data = rd_data;
      end
   end

   // result toward the output register
   always_comb begin
      res_valid = (state_ff == S_FINISH) || (take && held_valid_ff);
      res.status         = (state_ff == S_FINISH) ? status_ff : ST_OK;
      res.position       = held_valid_ff ? held_pos_ff : '0;
      res.found_key      = held_valid_ff ? held_ff.key : '0;
      res.found_category = held_valid_ff ? held_ff.category : '0;
      res.found_name     = held_valid_ff ? held_ff.name : '0;
      res.last           = (state_ff == S_FINISH);
   end

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state and register updates
   always_comb begin
      state_in      = state_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      cat_in        = cat_ff;
      head_in       = head_ff;
      count_in      = count_ff;
      rd_off_in     = rd_off_ff;
      d_off_in      = d_off_ff;
      start_in      = start_ff;
      dv_in         = dv_ff && stall;
      stop_in       = stop_ff;
      n_in          = n_ff;
      held_in       = held_ff;
      held_pos_in   = held_pos_ff;
      held_valid_in = held_valid_ff;
      status_in     = status_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in         = cmd.opcode;
               key_in        = cmd.record_key;
               cat_in        = cmd.record_category;
               held_valid_in = 1'b0;
               n_in          = '0;
               stop_in       = 1'b0;
               dv_in         = 1'b0;
               rd_off_in     = '0;
               unique case (cmd.opcode)
                  OP_APPEND: begin
                     state_in = S_FINISH;
                     if (count_ff == OFF'(QUEUE_DEPTH)) begin
                        status_in = ST_FULL;
                     end else begin
                        status_in     = ST_OK;
                        held_in       = cmd_rec;
                        held_pos_in   = app_pos_w[POS_W-1:0];
                        held_valid_in = 1'b1;
                        count_in      = count_ff + OFF'(1);
                     end
                  end
                  OP_DROP, OP_FIND_KEY, OP_FIND_CAT, OP_LIST: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_FINISH;
                     end else begin
                        state_in = S_WALK;
                     end
                  end
                  OP_REMOVE: begin
                     if (count_ff == '0) begin
                        status_in = ST_EMPTY;
                        state_in  = S_FINISH;
                     end else if (rm_off_w >= CW'(count_ff)) begin
                        status_in = ST_TOO_FEW;
                        state_in  = S_FINISH;
                     end else begin
                        start_in  = OFF'(rm_off_w);
                        rd_off_in = OFF'(rm_off_w);
                        state_in  = S_WALK;
                     end
                  end
                  default: begin
                     // unused opcodes are dropped silently
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_WALK: begin
            // issue the next read
            if (rd_en) begin
               rd_off_in = rd_off_ff + OFF'(1);
               d_off_in  = rd_off_ff;
               dv_in     = 1'b1;
            end
            // capture a hit, the previous one leaves as a non-final result
            if (take && !stall) begin
               held_in       = rd_rec;
               held_pos_in   = d_pos_w[POS_W-1:0];
               held_valid_in = 1'b1;
               n_in          = n_ff + NW'(1);
               if ((n_ff + NW'(1)) == cap) begin
                  stop_in = 1'b1;
               end
            end
            // removal: the target record is kept for the report
            if (!is_search && consume && (d_off_ff == start_ff)) begin
               held_in       = rd_rec;
               held_pos_in   = d_pos_w[POS_W-1:0];
               held_valid_in = 1'b1;
            end
            if (walk_done) begin
               state_in  = S_FINISH;
               status_in = (!is_search || held_valid_ff) ? ST_OK : ST_NOT_FOUND;
               if (op_ff == OP_DROP) begin
                  head_in  = (head_ff == IDX'(QUEUE_DEPTH - 1)) ? '0 : head_ff + IDX'(1);
                  count_in = count_ff - OFF'(1);
               end else if (!is_search) begin
                  count_in = count_ff - OFF'(1);
               end
            end
         end
         S_FINISH: begin
            if (res_ready) begin
               state_in = S_IDLE;
            end
         end
      endcase
   end

   // control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff       <= '0;
         count_ff      <= '0;
         dv_ff         <= 1'b0;
         stop_ff       <= 1'b0;
         n_ff          <= '0;
         held_valid_ff <= 1'b0;
      end else begin
         head_ff       <= head_in;
         count_ff      <= count_in;
         dv_ff         <= dv_in;
         stop_ff       <= stop_in;
         n_ff          <= n_in;
         held_valid_ff <= held_valid_in;
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      key_ff      <= key_in;
      cat_ff      <= cat_in;
      rd_off_ff   <= rd_off_in;
      d_off_ff    <= d_off_in;
      start_ff    <= start_in;
      held_ff     <= held_in;
      held_pos_ff <= held_pos_in;
      status_ff   <= status_in;
   end

   // occupancy never exceeds the store
   assert property (@(posedge clock) disable iff (reset)
      count_ff <= OFF'(QUEUE_DEPTH))
      else $error("entry count beyond queue depth");

   // head pointer stays inside the store
   assert property (@(posedge clock) disable iff (reset)
      OFF'(head_ff) < OFF'(QUEUE_DEPTH))
      else $error("head index out of range");

   // a shift write never hits the slot being read
   assert property (@(posedge clock) disable iff (reset)
      (rd_en && wr_en) |-> (rd_addr != wr_addr))
      else $error("ram read and write collide");

   // a new request is only taken once the previous one has fully left
   assert property (@(posedge clock) disable iff (reset)
      (res_valid && res.last && res_ready) |=> (state_ff == S_IDLE))
      else $error("engine did not return to idle after final result");

   // count changes only on an append or at the end of a walk
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_FINISH) |=> $stable(count_ff))
      else $error("entry count changed while reporting");

endmodule

>>> rtl/fifo_queue_with_key_search.sv
`timescale 1ns / 1ps
// top level of the keyed fifo queue: stream ports and the result register
// depends on fqks_pkg and fqks_engine

// Ordered queue of up to QUEUE_DEPTH records (key, category, name tag) held
// in one ram with a single read port. Append, drop head, find key, find
// category, remove interior and list all are requests on the req_ stream;
// each gives one or more results on the rsp_ stream, the final one marked
// by rsp_tlast. Append, a full or empty queue and too few entries go
// straight to the final result without a walk. Walking requests read one
// record per cycle from the ram from the first record they need while the
// rsp_ side does not stall, and a stalled rsp_ side holds the walk. The
// record store needs no clearing after reset; only records that were
// appended are ever reported.

module fifo_queue_with_key_search #(
   parameter int QUEUE_DEPTH = 16
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // opcode[2:0], record_key[49:3], record_category[57:50],
   // record_name[89:58], skip_amount[94:90], zero pad[95]
   input  logic [95:0] req_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // status[2:0], position[7:3], found_key[54:8], found_category[62:55],
   // found_name[94:63], zero pad[95]
   output logic [95:0] rsp_tdata,
   output logic        rsp_tlast
);

   import fqks_pkg::*;

   cmd_type cmd;
   logic    res_valid;
   logic    res_ready;
   rsp_type res;
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   // unpack the request
   assign cmd.opcode          = req_tdata[2:0];
   assign cmd.record_key      = req_tdata[49:3];
   assign cmd.record_category = req_tdata[57:50];
   assign cmd.record_name     = req_tdata[89:58];
   assign cmd.skip_amount     = req_tdata[94:90];

   fqks_engine #(
      .QUEUE_DEPTH (QUEUE_DEPTH)
   ) u_engine (
      .clock     (clock),
      .reset     (reset),
      .cmd_valid (req_tvalid),
      .cmd_ready (req_tready),
      .cmd       (cmd),
      .res_valid (res_valid),
      .res_ready (res_ready),
      .res       (res)
   );

   // output register, refilled in the cycle it drains
   assign res_ready = !rsp_valid_ff || rsp_tready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (res_ready) begin
         rsp_valid_ff <= res_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (res_ready && res_valid) begin
         rsp_data_ff <= res;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tlast  = rsp_data_ff.last;
   assign rsp_tdata  = {1'b0, rsp_data_ff.found_name, rsp_data_ff.found_category,
                        rsp_data_ff.found_key, rsp_data_ff.position,
                        rsp_data_ff.status};

endmodule
